>>> hw/rtl/assert_macros.svh
// assertion helpers used by i2a_ser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> hw/rtl/i2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package i2a_pkg;

  // width of the signed input value
  localparam int VALUE_BITS = 32;

  // decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1)
  function automatic int num_digits(input int bits);
    logic [127:0] p;
    logic [127:0] lim;
    int n;
    p = 128'd1;
    lim = 128'd1 << (bits - 1);
    n = 0;
    for (int j = 0; j < 40; j++) begin
      if (p <= lim) begin
        n++;
        p = p * 128'd10;
      end
    end
    return n;
  endfunction

  localparam int DIGITS       = num_digits(VALUE_BITS);
  localparam int DIG_IDX_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CMP_BITS     = VALUE_BITS + 4;
  localparam logic [DIG_IDX_BITS-1:0] LAST_IDX = DIG_IDX_BITS'(DIGITS - 1);

  // ascii codes, 6 bits wide
  localparam logic [5:0] ASCII_ZERO  = 6'd48;
  localparam logic [5:0] ASCII_MINUS = 6'd45;

  // d * 10^k at compare width
  function automatic logic [CMP_BITS-1:0] pow10_mul(input int k, input int d);
    logic [127:0] r;
    r = 128'd1;
    for (int j = 0; j < k; j++) begin
      r = r * 128'd10;
    end
    r = r * 128'(d);
    return r[CMP_BITS-1:0];
  endfunction

  typedef logic [9:0][CMP_BITS-1:0] thresh_t;
  typedef logic [DIGITS-1:0][3:0]   digits_t;

  // word handed from cell to cell
  typedef struct packed {
    logic                    neg;
    logic [VALUE_BITS-1:0]   rem;
    digits_t                 digits;
    logic                    started;
    logic [DIG_IDX_BITS-1:0] first;
  } stage_t;

endpackage
`default_nettype wire

>>> hw/rtl/i2a_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface i2a_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [i2a_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/i2a_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
`default_nettype none
// signed integer to decimal ascii text
// in_chan: one beat per signed value (valid/ready, accepted when both high).
// out_chan: one beat per character, most significant first; a leading '-'
//   for negative values, no leading zeros, zero gives "0"; last marks the
//   final character of each number.
// the input beat loads the first of the DIGITS digit cells, the number
//   passes through the cells in order, and the output register loads on
//   the edge that empties the last cell.
// throughput: one character per cycle while the receiver is ready, set by
//   the single character channel; a number has 1 to 11 characters.
// the chain of digit cells, one per power of ten, keeps accepting values
//   while earlier numbers are still being sent, up to one per cell.
// a stalled receiver holds the current character; the cells fill up and
//   in_chan.ready drops once all of them hold a number.
// reset (rst, synchronous) empties every cell and the output stage.
module signed_int_to_decimal_ascii_top (
  input  wire logic clk,
  input  wire logic rst,
  i2a_in_if.sink    in_chan,
  i2a_out_if.source out_chan
);

  localparam int N = i2a_pkg::DIGITS;

  i2a_pkg::stage_t  stg [N+1];
  logic [N:0]       vld;
  logic [N:0]       rdy;
  i2a_pkg::thresh_t thr [N];

  logic [i2a_pkg::VALUE_BITS-1:0] raw;
  logic                           neg;
  i2a_pkg::stage_t                head;

  // sign and magnitude of the incoming value
  assign raw = in_chan.value;
  assign neg = raw[i2a_pkg::VALUE_BITS-1];

  always_comb begin
    head         = '0;
    head.neg     = neg;
    head.rem     = neg ? (~raw + i2a_pkg::VALUE_BITS'(1)) : raw;
    head.started = 1'b0;
  end

  assign stg[0]        = head;
  assign vld[0]        = in_chan.valid;
  assign in_chan.ready = rdy[0];

  // chain of digit cells, most significant power first
  for (genvar i = 0; i < N; i++) begin : g_cell
    for (genvar d = 0; d < 10; d++) begin : g_thr
      assign thr[i][d] = i2a_pkg::pow10_mul(N - 1 - i, d);
    end

    i2a_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_data   (stg[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_data  (stg[i+1]),
      .pos       (i2a_pkg::DIG_IDX_BITS'(i)),
      .thresh    (thr[i])
    );
  end

  // character output stage
  i2a_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[N]),
    .in_ready (rdy[N]),
    .in_data  (stg[N]),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

>>> hw/rtl/i2a_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module i2a_cell (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire i2a_pkg::stage_t                  in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output i2a_pkg::stage_t                       out_data,
  input  wire logic [i2a_pkg::DIG_IDX_BITS-1:0] pos,
  input  wire i2a_pkg::thresh_t                 thresh
);

  logic            valid;
  i2a_pkg::stage_t data;
  i2a_pkg::stage_t data_next;
  logic [3:0]      dig;

  // digit is the largest d with d * 10^k not above the remainder
  always_comb begin
    dig = 4'd0;
    for (int d = 1; d < 10; d++) begin
      if ({4'b0, in_data.rem} >= thresh[d]) begin
        dig = 4'(d);
      end
    end
  end

  // take the digit out and record it in this cell's slot
  always_comb begin
    data_next = in_data;
    data_next.rem = in_data.rem - thresh[dig][i2a_pkg::VALUE_BITS-1:0];
    data_next.digits[pos] = dig;
    if (!in_data.started && dig != 4'd0) begin
      data_next.started = 1'b1;
      data_next.first = pos;
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/i2a_ser.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module i2a_ser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire i2a_pkg::stage_t in_data,
  i2a_out_if.source            out_chan
);

  logic                             busy;
  logic                             sign_phase;
  logic [i2a_pkg::DIG_IDX_BITS-1:0] idx;
  i2a_pkg::digits_t                 digits;
  logic                             is_last;
  logic                             out_beat;

  assign is_last  = !sign_phase && idx == i2a_pkg::LAST_IDX;
  assign out_beat = busy && out_chan.ready;
  assign in_ready = !busy || (out_chan.ready && is_last);

  // character shown for the current beat
  assign out_chan.valid     = busy;
  assign out_chan.last      = is_last;
  assign out_chan.character = sign_phase ? i2a_pkg::ASCII_MINUS
                                         : i2a_pkg::ASCII_ZERO + {2'b00, digits[idx]};

  // busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
    end else if (out_beat && is_last) begin
      busy <= 1'b0;
    end
  end

  // load a number or step to the next character
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sign_phase <= in_data.neg;
      idx        <= in_data.started ? in_data.first : i2a_pkg::LAST_IDX;
      digits     <= in_data.digits;
    end else if (out_beat && !is_last) begin
      if (sign_phase) begin
        sign_phase <= 1'b0;
      end else begin
        idx <= idx + i2a_pkg::DIG_IDX_BITS'(1);
      end
    end
  end

  `ASSERT_PROP(a_more_after_mid, clk, rst, (out_beat && !is_last) |=> busy)
  `ASSERT_PROP(a_sign_then_digit, clk, rst, (out_beat && sign_phase) |=> (!sign_phase && $stable(idx)))
  `ASSERT_NEVER(a_idx_range, clk, rst, busy && idx > i2a_pkg::LAST_IDX)

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int VB          = i2a_pkg::VALUE_BITS;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIRECTED  = 22;

  // one character of decimal text as it leaves the block
  typedef struct packed {
    logic [5:0] character;
    logic       last;
  } text_char_t;

  // directed row: text left empty means the predictor supplies it
  typedef struct {
    logic signed [VB-1:0] value;
    string                text;
  } directed_row_t;

  typedef enum int {RX_STEADY, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  i2a_in_if  in_chan ();
  i2a_out_if out_chan ();

  signed_int_to_decimal_ascii_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  text_char_t pending_chars [$];
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  int         burst_left     = 0;
  int         gap_max        = 0;
  bit         hold_request   = 1'b0;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{32'sd0,          "0"},
    '{32'sd1,          "1"},
    '{-32'sd1,         "-1"},
    '{32'sd9,          "9"},
    '{-32'sd9,         "-9"},
    '{32'sd10,         "10"},
    '{-32'sd10,        "-10"},
    '{32'sd7,          "7"},
    '{32'h7fff_ffff,   "2147483647"},
    '{32'h8000_0000,   "-2147483648"},
    '{32'h8000_0001,   "-2147483647"},
    '{32'sd1000000000, "1000000000"},
    '{32'sd999999999,  "999999999"},
    '{-32'sd999999999, "-999999999"},
    '{32'sd100,        ""},
    '{-32'sd100,       ""},
    '{32'sd12345,      ""},
    '{-32'sd98765,     ""},
    '{32'h5555_5555,   ""},
    '{32'haaaa_aaaa,   ""},
    '{32'h0f0f_0f0f,   ""},
    '{32'hf0f0_f0f0,   ""}
  };

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // queue the characters of a literal string
  function automatic void queue_text_chars(input string text);
    text_char_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.character = 6'(text[i]);
      c.last      = (i == text.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // decimal text of a signed value, sign first, no leading zeros
  function automatic void predict_decimal(input logic signed [VB-1:0] v);
    logic            neg;
    logic [VB-1:0]   mag;
    logic [3:0]      dig [$];
    text_char_t      c;
    neg = v[VB-1];
    mag = neg ? (~$unsigned(v) + 1'b1) : $unsigned(v);
    do begin
      dig.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      c.character = i2a_pkg::ASCII_MINUS;
      c.last      = 1'b0;
      pending_chars.push_back(c);
    end
    for (int i = 0; i < dig.size(); i++) begin
      c.character = i2a_pkg::ASCII_ZERO + 6'(dig[i]);
      c.last      = (i == dig.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // random value, weighted toward digit-count boundaries and extremes
  function automatic logic signed [VB-1:0] random_value();
    logic [VB-1:0] v;
    logic [VB-1:0] p;
    p = 1;
    case ($urandom_range(0, 5))
      0, 5: v = $urandom;
      1: v = $urandom_range(0, 99);
      2: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p - $urandom_range(0, 1);
      end
      3: v = $urandom_range(0, 1) ? (32'h7fff_ffff - $urandom_range(0, 3))
                                  : (32'h8000_0000 + $urandom_range(0, 3));
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) == 1 && v != 32'h8000_0000) v = ~v + 1'b1;
    return v;
  endfunction

  // offer one value, wait for its beat, then maybe idle
  task automatic send_value(input logic signed [VB-1:0] v, input string text);
    in_chan.valid <= 1'b1;
    in_chan.value <= v;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    if (text.len() != 0) queue_text_chars(text);
    else predict_decimal(v);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 10);
      if (gap_max > 0) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_value(random_value(), "");
  endtask

  // sender quiet until all text has come out
  task automatic wait_text_drained();
    in_chan.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // receiver: stall pattern in modes, plus a long hold-off on request
  initial begin : receiver
    rx_mode_t rx_mode;
    int       rx_left;
    out_chan.ready = 1'b0;
    rx_mode = RX_STEADY;
    rx_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_mode)
        RX_STEADY:   out_chan.ready <= 1'b1;
        RX_LIGHT:    out_chan.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_chan.ready <= (rx_left % 3 != 0);
        default:     out_chan.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // compare each character beat with the oldest prediction
  always @(posedge clk) begin : check_text
    text_char_t want;
    if (!rst && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %0d", out_chan.character));
      end else begin
        want = pending_chars.pop_front();
        if (out_chan.character !== want.character)
          report_mismatch($sformatf("character %0d, want %0d",
                                    out_chan.character, want.character));
        if (out_chan.last !== want.last)
          report_mismatch($sformatf("last %b, want %b on character %0d",
                                    out_chan.last, want.last, want.character));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    in_chan.valid = 1'b0;
    in_chan.value = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    gap_max = 4;
    for (int i = 0; i < N_DIRECTED; i++)
      send_value(directed_rows[i].value, directed_rows[i].text);

    // random with bursts and gaps
    gap_max = 6;
    send_random(90);
    wait_text_drained();

    // long receiver hold-off while values keep coming
    hold_request = 1'b1;
    gap_max = 0;
    send_random(30);

    // back-to-back, no sender idling
    send_random(40);

    // long gaps
    gap_max = 10;
    send_random(50);

    wait_text_drained();
    repeat (2 * i2a_pkg::DIGITS + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_in_if.sv
hw/rtl/i2a_out_if.sv
hw/rtl/i2a_cell.sv
hw/rtl/i2a_ser.sv
hw/rtl/signed_int_to_decimal_ascii_top.sv
bench/tb_top.sv
